// ===== rtl/wifi_beacon_field_extractor_macros.svh =====
// Assertion helpers shared by the extractor modules.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef WIFI_BEACON_FIELD_EXTRACTOR_MACROS_SVH
`define WIFI_BEACON_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WBFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WBFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/wbfe_pkg.sv =====
package wbfe_pkg;

	// Default limits of the parser.
	localparam int MAX_PRESENT_WORDS_DEF = 16;
	localparam int MAX_SSID_BYTES_DEF    = 32;

	// Bit 31 of a present word chains to the next word; it is bit 7 of the fourth byte.
	localparam int CHAIN_EXT_BIT = 31;
	localparam int EXT_BYTE_BIT  = CHAIN_EXT_BIT - 24;

	// Widths of the frame counters.
	localparam int POS_W = 17;
	localparam int PWC_W = 5;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// Byte positions of the radiotap length.
	localparam int HDR_LO_POS = 2;
	localparam int HDR_HI_POS = 3;

	// Offsets from the end of the present words.
	localparam int CHAN_LO_OFS = 14;
	localparam int CHAN_HI_OFS = 15;
	localparam int RSSI_OFS    = 18;

	// Offsets from the radiotap length.
	localparam int BSSID_OFS     = 16;
	localparam int BSSID_END_OFS = 22;
	localparam int SLEN_OFS      = 37;
	localparam int SSID_OFS      = 38;

	// Bits of the reached mask.
	localparam int RM_CHAN  = 0;
	localparam int RM_RSSI  = 1;
	localparam int RM_BSSID = 2;
	localparam int RM_SLEN  = 3;
	localparam int RM_HDR   = 4;
	localparam int RM_W     = 5;

	// Result kinds.
	localparam logic KIND_SSID    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Depth of the result queue; a power of two.
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic               item_kind;
		logic [7:0]         ssid_char;
		logic [4:0]         ssid_position;
		logic [15:0]        channel_mhz;
		logic signed [8:0]  rssi_dbm;
		logic [47:0]        bssid_addr;
		logic [7:0]         ssid_length;
		logic               fields_complete;
		logic               ssid_truncated;
		logic               run_last;
	} result_t;

	typedef struct packed {
		logic push_a;
		logic push_b;
	} push_ctl_t;

endpackage

// ===== rtl/wbfe_byte_if.sv =====
interface wbfe_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] pkt_byte;
	logic       pkt_last;

	modport source (output valid, output pkt_byte, output pkt_last, input ready);
	modport sink (input valid, input pkt_byte, input pkt_last, output ready);
endinterface

// ===== rtl/wbfe_result_if.sv =====
interface wbfe_result_if;
	logic               valid;
	logic               ready;
	logic               item_kind;
	logic [7:0]         ssid_char;
	logic [4:0]         ssid_position;
	logic [15:0]        channel_mhz;
	logic signed [8:0]  rssi_dbm;
	logic [47:0]        bssid_addr;
	logic [7:0]         ssid_length;
	logic               fields_complete;
	logic               ssid_truncated;
	logic               run_last;

	modport source (
		output valid, output item_kind, output ssid_char, output ssid_position,
		output channel_mhz, output rssi_dbm, output bssid_addr, output ssid_length,
		output fields_complete, output ssid_truncated, output run_last,
		input ready
	);
	modport sink (
		input valid, input item_kind, input ssid_char, input ssid_position,
		input channel_mhz, input rssi_dbm, input bssid_addr, input ssid_length,
		input fields_complete, input ssid_truncated, input run_last,
		output ready
	);
endinterface

// ===== rtl/wbfe_parse_core.sv =====
`include "wifi_beacon_field_extractor_macros.svh"

module wbfe_parse_core #(
	parameter int MAX_PRESENT_WORDS = wbfe_pkg::MAX_PRESENT_WORDS_DEF,
	parameter int MAX_SSID_BYTES    = wbfe_pkg::MAX_SSID_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          pkt_byte,
	input  logic                pkt_last,
	output wbfe_pkg::push_ctl_t push,
	output wbfe_pkg::result_t   res_a,
	output wbfe_pkg::result_t   res_b
);

	localparam int POS_W = wbfe_pkg::POS_W;
	localparam int PWC_W = wbfe_pkg::PWC_W;
	localparam int RM_W  = wbfe_pkg::RM_W;
	localparam int REL_W = POS_W + 1;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [15:0]      hdr_len_q, hdr_len_d;
	logic [PWC_W-1:0] pw_count_q, pw_count_d;
	logic             chain_open_q, chain_open_d;
	logic [15:0]      chan_q, chan_d;
	logic [7:0]       rssi_q, rssi_d;
	logic [47:0]      bssid_q, bssid_d;
	logic [7:0]       slen_q, slen_d;
	logic [RM_W-1:0]  reached_q, reached_d;

	logic             chain_hit;
	logic [POS_W-1:0] base_pos;
	logic [REL_W-1:0] rel, ssid_ofs;
	logic             rel_neg, hdr_ok;
	logic [7:0]       lim;
	logic             emit, trunc;
	wbfe_pkg::result_t ssid_res, sum_res;

	// Radiotap length and present-word chain.
	always_comb begin
		hdr_len_d    = hdr_len_q;
		pw_count_d   = pw_count_q;
		chain_open_d = chain_open_q;
		reached_d    = reached_q;
		if (pos_q == POS_W'(wbfe_pkg::HDR_LO_POS)) begin
			hdr_len_d[7:0] = pkt_byte;
		end
		if (pos_q == POS_W'(wbfe_pkg::HDR_HI_POS)) begin
			hdr_len_d[15:8] = pkt_byte;
			reached_d[wbfe_pkg::RM_HDR] = 1'b1;
		end
		chain_hit = chain_open_q && (pos_q == POS_W'({pw_count_q, 2'b11}));
		if (chain_hit) begin
			if (pkt_byte[wbfe_pkg::EXT_BYTE_BIT] && (pw_count_q < PWC_W'(MAX_PRESENT_WORDS))) begin
				pw_count_d = pw_count_q + PWC_W'(1);
			end else begin
				chain_open_d = 1'b0;
			end
		end
	end

	// Radiotap fields, placed after the odd-rounded present words.
	assign base_pos = POS_W'({pw_count_d | PWC_W'(1), 2'b00});

	always_comb begin
		chan_d = chan_q;
		rssi_d = rssi_q;
		if (!chain_open_d) begin
			if (pos_q == base_pos + POS_W'(wbfe_pkg::CHAN_LO_OFS)) begin
				chan_d[7:0] = pkt_byte;
			end
			if (pos_q == base_pos + POS_W'(wbfe_pkg::CHAN_HI_OFS)) begin
				chan_d[15:8] = pkt_byte;
			end
			if (pos_q == base_pos + POS_W'(wbfe_pkg::RSSI_OFS)) begin
				rssi_d = pkt_byte;
			end
		end
	end

	// Frame fields relative to the radiotap length.
	assign rel      = {1'b0, pos_q} - REL_W'(hdr_len_q);
	assign rel_neg  = rel[REL_W-1];
	assign hdr_ok   = reached_q[wbfe_pkg::RM_HDR] && !rel_neg;
	assign ssid_ofs = rel - REL_W'(wbfe_pkg::SSID_OFS);

	always_comb begin
		bssid_d = bssid_q;
		slen_d  = slen_q;
		if (hdr_ok && (rel >= REL_W'(wbfe_pkg::BSSID_OFS))
				&& (rel < REL_W'(wbfe_pkg::BSSID_END_OFS))) begin
			bssid_d = {bssid_q[39:0], pkt_byte};
		end
		if (hdr_ok && (rel == REL_W'(wbfe_pkg::SLEN_OFS))) begin
			slen_d = pkt_byte;
		end
	end

	// Reached flags for the channel, RSSI, BSSID and SSID length.
	logic [RM_W-1:0] reached_f;
	always_comb begin
		reached_f = reached_d;
		if (!chain_open_d && (pos_q == base_pos + POS_W'(wbfe_pkg::CHAN_HI_OFS))) begin
			reached_f[wbfe_pkg::RM_CHAN] = 1'b1;
		end
		if (!chain_open_d && (pos_q == base_pos + POS_W'(wbfe_pkg::RSSI_OFS))) begin
			reached_f[wbfe_pkg::RM_RSSI] = 1'b1;
		end
		if (hdr_ok && (rel == REL_W'(wbfe_pkg::BSSID_END_OFS - 1))) begin
			reached_f[wbfe_pkg::RM_BSSID] = 1'b1;
		end
		if (hdr_ok && (rel == REL_W'(wbfe_pkg::SLEN_OFS))) begin
			reached_f[wbfe_pkg::RM_SLEN] = 1'b1;
		end
	end

	// SSID byte window and truncation check.
	assign lim = (slen_d < 8'(MAX_SSID_BYTES)) ? slen_d : 8'(MAX_SSID_BYTES);
	assign emit = hdr_ok && reached_f[wbfe_pkg::RM_SLEN]
		&& (rel >= REL_W'(wbfe_pkg::SSID_OFS)) && (ssid_ofs < REL_W'(lim));
	assign trunc = !reached_f[wbfe_pkg::RM_SLEN] || (slen_d > 8'(MAX_SSID_BYTES)) || rel_neg
		|| (rel < REL_W'(wbfe_pkg::SSID_OFS - 1) + REL_W'(lim));

	// Result items.
	always_comb begin
		ssid_res               = '0;
		ssid_res.item_kind     = wbfe_pkg::KIND_SSID;
		ssid_res.ssid_char     = pkt_byte;
		ssid_res.ssid_position = ssid_ofs[4:0];
		ssid_res.run_last      = !pkt_last;

		sum_res                 = '0;
		sum_res.item_kind       = wbfe_pkg::KIND_SUMMARY;
		sum_res.channel_mhz     = chan_d;
		sum_res.rssi_dbm        = $signed({1'b1, rssi_d});
		sum_res.bssid_addr      = bssid_d;
		sum_res.ssid_length     = slen_d;
		sum_res.fields_complete = &reached_f;
		sum_res.ssid_truncated  = trunc;
		sum_res.run_last        = 1'b1;
	end

	assign push.push_a = step && (emit || pkt_last);
	assign push.push_b = step && emit && pkt_last;
	assign res_a       = emit ? ssid_res : sum_res;
	assign res_b       = sum_res;

	// State update; the final byte returns the parser to its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			hdr_len_q    <= '0;
			pw_count_q   <= PWC_W'(1);
			chain_open_q <= 1'b1;
			chan_q       <= '0;
			rssi_q       <= '0;
			bssid_q      <= '0;
			slen_q       <= '0;
			reached_q    <= '0;
		end else if (step) begin
			if (pkt_last) begin
				pos_q        <= '0;
				hdr_len_q    <= '0;
				pw_count_q   <= PWC_W'(1);
				chain_open_q <= 1'b1;
				chan_q       <= '0;
				rssi_q       <= '0;
				bssid_q      <= '0;
				slen_q       <= '0;
				reached_q    <= '0;
			end else begin
				if (pos_q != wbfe_pkg::POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				hdr_len_q    <= hdr_len_d;
				pw_count_q   <= pw_count_d;
				chain_open_q <= chain_open_d;
				chan_q       <= chan_d;
				rssi_q       <= rssi_d;
				bssid_q      <= bssid_d;
				slen_q       <= slen_d;
				reached_q    <= reached_f;
			end
		end
	end

	// Checks on the parser state.
	`WBFE_ASSERT_NEXT(a_last_clears_pos, step && pkt_last, pos_q == '0, "frame end did not clear position")
	`WBFE_ASSERT_NOW(a_pw_count_range, 1'b1, (pw_count_q != '0) && (pw_count_q <= PWC_W'(MAX_PRESENT_WORDS)), "present word count out of range")
	`WBFE_ASSERT_NOW(a_pair_order, push.push_b, push.push_a && (res_a.item_kind == wbfe_pkg::KIND_SSID) && (res_b.item_kind == wbfe_pkg::KIND_SUMMARY), "result pair out of order")

endmodule

// ===== rtl/wbfe_result_fifo.sv =====
`include "wifi_beacon_field_extractor_macros.svh"

module wbfe_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  wbfe_pkg::push_ctl_t push,
	input  wbfe_pkg::result_t   res_a,
	input  wbfe_pkg::result_t   res_b,
	output logic                space_two,
	output logic                out_valid,
	input  logic                out_ready,
	output wbfe_pkg::result_t   out_res
);

	localparam int DEPTH = wbfe_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wbfe_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign space_two = (count_q <= CNT_W'(DEPTH - 2));

	// Storage: up to two writes per cycle at consecutive slots.
	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem_q[wr_ptr_q] <= res_a;
		end
		if (push.push_b) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= res_b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.push_a) + PTR_W'(push.push_b);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(push.push_a) + CNT_W'(push.push_b) - CNT_W'(pop);
		end
	end

	// Checks on the queue bookkeeping.
	`WBFE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "result queue overfilled")
	`WBFE_ASSERT_NOW(a_push_room, push.push_a, space_two, "push without room for a result pair")
	`WBFE_ASSERT_NEXT(a_pop_count, pop && !push.push_a, count_q == $past(count_q) - CNT_W'(1), "pop did not lower fill count")

endmodule

// ===== rtl/wifi_beacon_field_extractor.sv =====
// Beacon field extractor for radiotap-wrapped 802.11 frames.
// The frame channel carries one captured byte per transfer, with pkt_last set
// on the final byte of a frame. The report channel carries result items: one
// item per SSID byte (up to MAX_SSID_BYTES per frame), and a summary item on
// the final byte with channel, RSSI, BSSID, SSID length and status flags.
// run_last marks the final item caused by one input byte.
// Each accepted byte is held in an input register; the parse logic then
// writes its results into a four-entry result queue, from which they are
// offered on the report channel. One byte is taken every cycle while the
// receiver keeps up; a final byte that also carries an SSID byte puts two
// items in the queue, the SSID item ahead of the summary.
// When the receiver stalls, the queue fills, and frame.ready falls while a byte
// is held and fewer than two queue entries are free; no item is dropped.
// Reset clears the input valid flag, the queue and the parse state, which also
// returns to its reset values after every final byte.

module wifi_beacon_field_extractor #(
	parameter int MAX_PRESENT_WORDS = wbfe_pkg::MAX_PRESENT_WORDS_DEF,
	parameter int MAX_SSID_BYTES    = wbfe_pkg::MAX_SSID_BYTES_DEF
) (
	input logic           clk,
	input logic           arst_n,
	wbfe_byte_if.sink     frame,
	wbfe_result_if.source report
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       step;
	logic       space_two;

	wbfe_pkg::push_ctl_t push;
	wbfe_pkg::result_t   res_a, res_b, out_res;

	// The held byte is parsed when the queue has room for a result pair.
	assign step        = valid_s1 && space_two;
	assign frame.ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.pkt_byte;
			last_s1 <= frame.pkt_last;
		end
	end

	wbfe_parse_core #(
		.MAX_PRESENT_WORDS(MAX_PRESENT_WORDS),
		.MAX_SSID_BYTES(MAX_SSID_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.pkt_byte(byte_s1),
		.pkt_last(last_s1),
		.push(push),
		.res_a(res_a),
		.res_b(res_b)
	);

	wbfe_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res_a(res_a),
		.res_b(res_b),
		.space_two(space_two),
		.out_valid(report.valid),
		.out_ready(report.ready),
		.out_res(out_res)
	);

	// Result payload onto the report channel.
	assign report.item_kind       = out_res.item_kind;
	assign report.ssid_char       = out_res.ssid_char;
	assign report.ssid_position   = out_res.ssid_position;
	assign report.channel_mhz     = out_res.channel_mhz;
	assign report.rssi_dbm        = out_res.rssi_dbm;
	assign report.bssid_addr      = out_res.bssid_addr;
	assign report.ssid_length     = out_res.ssid_length;
	assign report.fields_complete = out_res.fields_complete;
	assign report.ssid_truncated  = out_res.ssid_truncated;
	assign report.run_last        = out_res.run_last;

endmodule
